[hw/rtl/quaternion_product_rotate_unit_defines.svh]
// Assertion helpers for the quaternion unit checkers.
// Both macros expect signals named clk and rst_n in the scope of use.
`ifndef QUATERNION_PRODUCT_ROTATE_UNIT_DEFINES_SVH
`define QUATERNION_PRODUCT_ROTATE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define QPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define QPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/qpr_pkg.sv]
package qpr_pkg;

  localparam int DW   = 32;            // component width, Q2.30
  localparam int FRAC = 30;            // fraction bits
  localparam int PW   = 2 * DW;        // component product
  localparam int CW   = PW + 1;        // cross product difference
  localparam int TW   = 35;            // rotation intermediate t, Q.30
  localparam int RW   = DW + TW;       // component times t
  localparam int SW   = 68;            // accumulated sums
  localparam int RDW  = SW - FRAC + 1; // sum after rounding shift

  typedef logic signed [DW-1:0] comp_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [TW-1:0] tvec_t;
  typedef logic signed [RW-1:0] rprod_t;
  typedef logic signed [SW-1:0] sum_t;

  localparam logic [2:0] CMD_MUL      = 3'd0;
  localparam logic [2:0] CMD_CONJ_A   = 3'd1;
  localparam logic [2:0] CMD_CONJ_B   = 3'd2;
  localparam logic [2:0] CMD_ROT      = 3'd3;
  localparam logic [2:0] CMD_ROT_CONJ = 3'd4;

  localparam comp_t SAT_MAX = 32'sh7FFF_FFFF;
  localparam comp_t SAT_MIN = 32'sh8000_0000;

  // Decoded operation, carried down the pipe with each request.
  typedef struct packed {
    logic quat;     // one of the Hamilton products
    logic conj_a;
    logic conj_b;
    logic rot;      // vector rotation
    logic rot_neg;  // rotation by conj(a): flip the scalar term
  } op_t;

  // Base sign of product term k (a index k, b index c^k) of component c.
  localparam logic [3:0] TERM_NEG [4] = '{4'b1110, 4'b0100, 4'b1000, 4'b0010};

  function automatic op_t decode_cmd(input logic [2:0] cmd);
    op_t op;
    op = '0;
    unique case (cmd)
      CMD_MUL: begin
        op.quat = 1'b1;
      end
      CMD_CONJ_A: begin
        op.quat   = 1'b1;
        op.conj_a = 1'b1;
      end
      CMD_CONJ_B: begin
        op.quat   = 1'b1;
        op.conj_b = 1'b1;
      end
      CMD_ROT: begin
        op.rot = 1'b1;
      end
      CMD_ROT_CONJ: begin
        op.rot     = 1'b1;
        op.rot_neg = 1'b1;
      end
      default: begin
        op = '0;
      end
    endcase
    return op;
  endfunction

endpackage

[hw/rtl/qpr_mul.sv]
module qpr_mul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            valid_i,
  input  logic [2:0]      cmd_i,
  input  qpr_pkg::comp_t  a_i [4],
  input  qpr_pkg::comp_t  b_i [4],
  output logic            valid_o,
  output qpr_pkg::op_t    op_o,
  output qpr_pkg::prod_t  prod_o [16],
  output qpr_pkg::comp_t  a_o [4],
  output qpr_pkg::comp_t  v_o [3]
);
  import qpr_pkg::*;

  logic  valid_r;
  op_t   op_r;
  prod_t prod_r [16];
  prod_t prod_nxt [16];
  comp_t a_r [4];
  comp_t v_r [3];

  // All sixteen a_i * b_j products; the rotation reuses the vector ones.
  for (genvar i = 0; i < 4; i++) begin : g_row
    for (genvar j = 0; j < 4; j++) begin : g_col
      assign prod_nxt[i*4+j] = a_i[i] * b_i[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en && valid_i) begin
      op_r   <= decode_cmd(cmd_i);
      prod_r <= prod_nxt;
      a_r    <= a_i;
      v_r[0] <= b_i[1];
      v_r[1] <= b_i[2];
      v_r[2] <= b_i[3];
    end
  end

  assign valid_o = valid_r;
  assign op_o    = op_r;
  assign prod_o  = prod_r;
  assign a_o     = a_r;
  assign v_o     = v_r;

endmodule

[hw/rtl/qpr_accum.sv]
module qpr_accum (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            valid_i,
  input  qpr_pkg::op_t    op_i,
  input  qpr_pkg::prod_t  prod_i [16],
  input  qpr_pkg::comp_t  a_i [4],
  input  qpr_pkg::comp_t  v_i [3],
  output logic            valid_o,
  output qpr_pkg::op_t    op_o,
  output qpr_pkg::sum_t   q_o [4],
  output qpr_pkg::tvec_t  t_o [3],
  output qpr_pkg::comp_t  a_o [4],
  output qpr_pkg::comp_t  v_o [3]
);
  import qpr_pkg::*;

  // Half an LSB of t; 2c rounded at bit 30 equals c rounded at bit 29.
  localparam logic signed [CW:0] T_HALF = (CW + 1)'(1) << (FRAC - 2);

  logic  valid_r;
  op_t   op_r;
  sum_t  term [4][4];
  sum_t  q_nxt [4];
  sum_t  q_r [4];
  logic signed [CW-1:0] cr [3];
  logic signed [CW:0]   cr_rnd [3];
  tvec_t t_nxt [3];
  tvec_t t_r [3];
  comp_t a_r [4];
  comp_t v_r [3];

  // Signed four-term sums of the Hamilton product.
  for (genvar c = 0; c < 4; c++) begin : g_comp
    for (genvar k = 0; k < 4; k++) begin : g_term
      localparam int J = c ^ k;
      logic flip;
      assign flip = TERM_NEG[c][k] ^ (op_i.conj_a & 1'(k != 0))
                                   ^ (op_i.conj_b & 1'(J != 0));
      assign term[c][k] = flip ? -SW'(prod_i[k*4+J]) : SW'(prod_i[k*4+J]);
    end
    assign q_nxt[c] = term[c][0] + term[c][1] + term[c][2] + term[c][3];
  end

  // t = 2 (av x v), rounded to Q.30.
  for (genvar j = 0; j < 3; j++) begin : g_cross
    localparam int P = (j + 1) % 3 + 1;
    localparam int N = (j + 2) % 3 + 1;
    assign cr[j]     = CW'(prod_i[P*4+N]) - CW'(prod_i[N*4+P]);
    assign cr_rnd[j] = (CW + 1)'(cr[j]) + T_HALF;
    assign t_nxt[j]  = cr_rnd[j][TW+FRAC-2:FRAC-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en && valid_i) begin
      op_r <= op_i;
      q_r  <= q_nxt;
      t_r  <= t_nxt;
      a_r  <= a_i;
      v_r  <= v_i;
    end
  end

  assign valid_o = valid_r;
  assign op_o    = op_r;
  assign q_o     = q_r;
  assign t_o     = t_r;
  assign a_o     = a_r;
  assign v_o     = v_r;

endmodule

[hw/rtl/qpr_rotmul.sv]
module qpr_rotmul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            valid_i,
  input  qpr_pkg::op_t    op_i,
  input  qpr_pkg::sum_t   q_i [4],
  input  qpr_pkg::tvec_t  t_i [3],
  input  qpr_pkg::comp_t  a_i [4],
  input  qpr_pkg::comp_t  v_i [3],
  output logic            valid_o,
  output qpr_pkg::op_t    op_o,
  output qpr_pkg::sum_t   q_o [4],
  output qpr_pkg::rprod_t pp_o [3],
  output qpr_pkg::rprod_t pn_o [3],
  output qpr_pkg::rprod_t pw_o [3],
  output qpr_pkg::comp_t  v_o [3]
);
  import qpr_pkg::*;

  logic   valid_r;
  op_t    op_r;
  sum_t   q_r [4];
  rprod_t pp_nxt [3];
  rprod_t pn_nxt [3];
  rprod_t pw_nxt [3];
  rprod_t pp_r [3];
  rprod_t pn_r [3];
  rprod_t pw_r [3];
  comp_t  v_r [3];

  // Cross product av x t split in its two terms, plus aw * t.
  for (genvar j = 0; j < 3; j++) begin : g_rot
    localparam int P = (j + 1) % 3 + 1;
    localparam int N = (j + 2) % 3 + 1;
    assign pp_nxt[j] = a_i[P] * t_i[N-1];
    assign pn_nxt[j] = a_i[N] * t_i[P-1];
    assign pw_nxt[j] = a_i[0] * t_i[j];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en && valid_i) begin
      op_r <= op_i;
      q_r  <= q_i;
      pp_r <= pp_nxt;
      pn_r <= pn_nxt;
      pw_r <= pw_nxt;
      v_r  <= v_i;
    end
  end

  assign valid_o = valid_r;
  assign op_o    = op_r;
  assign q_o     = q_r;
  assign pp_o    = pp_r;
  assign pn_o    = pn_r;
  assign pw_o    = pw_r;
  assign v_o     = v_r;

endmodule

[hw/rtl/qpr_out.sv]
module qpr_out (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_i,
  input  logic            stall_i,
  input  qpr_pkg::op_t    op_i,
  input  qpr_pkg::sum_t   q_i [4],
  input  qpr_pkg::rprod_t pp_i [3],
  input  qpr_pkg::rprod_t pn_i [3],
  input  qpr_pkg::rprod_t pw_i [3],
  input  qpr_pkg::comp_t  v_i [3],
  output logic            adv_o,
  output logic            valid_o,
  output qpr_pkg::comp_t  r_o [4],
  output logic            ovf_o
);
  import qpr_pkg::*;

  localparam logic signed [SW:0] R_HALF = (SW + 1)'(1) << (FRAC - 1);

  logic  en_sel;
  logic  en_fin;
  logic  sel_valid_r;
  sum_t  rot [3];
  sum_t  s_nxt [4];
  sum_t  s_r [4];
  logic signed [SW:0]    s_rnd [4];
  logic signed [RDW-1:0] s_q [4];
  logic  [3:0] sat;
  comp_t r_nxt [4];
  logic  fin_valid_r;
  comp_t r_r [4];
  logic  ovf_r;

  assign en_fin = !fin_valid_r || !stall_i;
  assign en_sel = !sel_valid_r || en_fin;

  // r = v + aw t + av x t, all at Q.60.
  for (genvar j = 0; j < 3; j++) begin : g_rot
    assign rot[j] = SW'(pp_i[j]) - SW'(pn_i[j])
                  + (op_i.rot_neg ? -SW'(pw_i[j]) : SW'(pw_i[j]))
                  + (SW'(v_i[j]) <<< FRAC);
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      s_nxt[c] = '0;
    end
    if (op_i.quat) begin
      s_nxt = q_i;
    end else if (op_i.rot) begin
      for (int j = 0; j < 3; j++) begin
        s_nxt[j+1] = rot[j];
      end
    end
  end

  // Round to nearest, ties up, then clamp to 32 bits.
  for (genvar c = 0; c < 4; c++) begin : g_sat
    assign s_rnd[c] = (SW + 1)'(s_r[c]) + R_HALF;
    assign s_q[c]   = s_rnd[c][SW:FRAC];
    assign sat[c]   = (s_q[c][RDW-1:DW-1] != '0) && (s_q[c][RDW-1:DW-1] != '1);
    assign r_nxt[c] = !sat[c] ? s_q[c][DW-1:0]
                    : (s_q[c][RDW-1] ? SAT_MIN : SAT_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_valid_r <= 1'b0;
      fin_valid_r <= 1'b0;
    end else begin
      if (en_sel) begin
        sel_valid_r <= valid_i;
      end
      if (en_fin) begin
        fin_valid_r <= sel_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_sel && valid_i) begin
      s_r <= s_nxt;
    end
    if (en_fin && sel_valid_r) begin
      r_r   <= r_nxt;
      ovf_r <= |sat;
    end
  end

  assign adv_o   = en_sel;
  assign valid_o = fin_valid_r;
  assign r_o     = r_r;
  assign ovf_o   = ovf_r;

endmodule

[hw/rtl/quaternion_product_rotate_unit.sv]
// Channel   Handshake                Payload
// in        in_valid / in_stall      in_command, in_a_w..in_a_z, in_b_w..in_b_z
// out       out_valid / out_stall    out_r_w..out_r_z, out_overflow
//
// Five register stages; a request taken at one edge reaches out_valid through all five
// when nothing stalls, and one request can enter every cycle while in_stall is low.
// The depth is set by two multiplier ranks: the a x b products and a x t.
// Reset (rst_n low, synchronous) clears every stage valid bit; data is unreset.
// A stalled output holds; each stage still fills while its successor is empty,
// so in_stall rises only once every stage holds a request.
module quaternion_product_rotate_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_a_w,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_w,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_r_w,
  output logic signed [31:0] out_r_x,
  output logic signed [31:0] out_r_y,
  output logic signed [31:0] out_r_z,
  output logic               out_overflow
);
  import qpr_pkg::*;

  // Operand vectors, index 0 is the scalar part.
  comp_t a_in [4];
  comp_t b_in [4];

  // Stage 1: products.
  logic  v1;
  op_t   op1;
  prod_t prod1 [16];
  comp_t a1 [4];
  comp_t vec1 [3];

  // Stage 2: quaternion sums and t.
  logic  v2;
  op_t   op2;
  sum_t  q2 [4];
  tvec_t t2 [3];
  comp_t a2 [4];
  comp_t vec2 [3];

  // Stage 3: products with t.
  logic   v3;
  op_t    op3;
  sum_t   q3 [4];
  rprod_t pp3 [3];
  rprod_t pn3 [3];
  rprod_t pw3 [3];
  comp_t  vec3 [3];

  // Stages 4 and 5 live in the output block.
  comp_t r_out [4];
  logic  adv4;
  logic  en1;
  logic  en2;
  logic  en3;

  assign a_in[0] = in_a_w;
  assign a_in[1] = in_a_x;
  assign a_in[2] = in_a_y;
  assign a_in[3] = in_a_z;
  assign b_in[0] = in_b_w;
  assign b_in[1] = in_b_x;
  assign b_in[2] = in_b_y;
  assign b_in[3] = in_b_z;

  // Advance a stage when it is empty or the next one advances; bubbles
  // collapse, and a full stalled stage holds its request.
  assign en3 = !v3 || adv4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall = !en1;

  qpr_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en1),
    .valid_i (in_valid),
    .cmd_i   (in_command),
    .a_i     (a_in),
    .b_i     (b_in),
    .valid_o (v1),
    .op_o    (op1),
    .prod_o  (prod1),
    .a_o     (a1),
    .v_o     (vec1)
  );

  qpr_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en2),
    .valid_i (v1),
    .op_i    (op1),
    .prod_i  (prod1),
    .a_i     (a1),
    .v_i     (vec1),
    .valid_o (v2),
    .op_o    (op2),
    .q_o     (q2),
    .t_o     (t2),
    .a_o     (a2),
    .v_o     (vec2)
  );

  qpr_rotmul u_rotmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en3),
    .valid_i (v2),
    .op_i    (op2),
    .q_i     (q2),
    .t_i     (t2),
    .a_i     (a2),
    .v_i     (vec2),
    .valid_o (v3),
    .op_o    (op3),
    .q_o     (q3),
    .pp_o    (pp3),
    .pn_o    (pn3),
    .pw_o    (pw3),
    .v_o     (vec3)
  );

  // Select product or rotation, round, saturate, and hold for the consumer.
  qpr_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v3),
    .stall_i (out_stall),
    .op_i    (op3),
    .q_i     (q3),
    .pp_i    (pp3),
    .pn_i    (pn3),
    .pw_i    (pw3),
    .v_i     (vec3),
    .adv_o   (adv4),
    .valid_o (out_valid),
    .r_o     (r_out),
    .ovf_o   (out_overflow)
  );

  assign out_r_w = r_out[0];
  assign out_r_x = r_out[1];
  assign out_r_y = r_out[2];
  assign out_r_z = r_out[3];

endmodule

[hw/rtl/qpr_checker.sv]
`include "quaternion_product_rotate_unit_defines.svh"

module qpr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_r_w,
  input logic signed [31:0] out_r_x,
  input logic signed [31:0] out_r_y,
  input logic signed [31:0] out_r_z,
  input logic               out_overflow
);
  import qpr_pkg::*;

  // Hold a stalled result.
  `QPR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_r_w) && $stable(out_r_x) && $stable(out_r_y) && $stable(out_r_z) && $stable(out_overflow), "stalled result changed")

  // Back-pressure only when the pipe is full behind a stalled result.
  `QPR_ASSERT_IMP(a_in_stall_full, in_stall, out_valid && out_stall, "input stalled with room in pipe")

  // An overflow flag comes with at least one clamped component.
  `QPR_ASSERT_IMP(a_ovf_clamped, out_valid && out_overflow, out_r_w == SAT_MAX || out_r_w == SAT_MIN || out_r_x == SAT_MAX || out_r_x == SAT_MIN || out_r_y == SAT_MAX || out_r_y == SAT_MIN || out_r_z == SAT_MAX || out_r_z == SAT_MIN, "overflow without saturated component")

  // A taken request shows on out_valid after every stage when out_stall stays low.
  `QPR_ASSERT_NXT(a_latency, in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid, "result missing after pipeline latency")

endmodule

bind quaternion_product_rotate_unit qpr_checker u_qpr_checker (.*);

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
  import qpr_pkg::*;

  // Commands past the last defined one; the unit must answer them with zeros.
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  localparam comp_t ONE_Q30      = 32'sh4000_0000;
  localparam comp_t MINUS_ONE_Q30 = -32'sh4000_0000;
  localparam comp_t HALF_LSB_Q30 = 32'sh2000_0000;   // 2^29: half an LSB after the shift
  localparam int    WATCHDOG_LIMIT = 4000;
  localparam int    DRAIN_CYCLES   = 20;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [2:0] cmd;
    comp_t      aw, ax, ay, az;
    comp_t      bw, bx, by, bz;
  } quat_req_t;

  typedef struct packed {
    comp_t rw, rx, ry, rz;
    logic  ovf;
  } quat_res_t;

  logic  clk          = 1'b0;
  logic  rst_n        = 1'b0;
  logic  in_valid     = 1'b0;
  logic  in_stall;
  logic  [2:0] in_command = '0;
  comp_t in_a_w = '0, in_a_x = '0, in_a_y = '0, in_a_z = '0;
  comp_t in_b_w = '0, in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic  out_valid;
  logic  out_stall    = 1'b0;
  comp_t out_r_w, out_r_x, out_r_y, out_r_z;
  logic  out_overflow;

  quat_res_t pending_results[$];
  int        mismatches   = 0;
  int        stall_left   = 0;
  int        quiet_cycles = 0;
  bit        no_gaps      = 1'b0;

  quaternion_product_rotate_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_a_w       (in_a_w),
    .in_a_x       (in_a_x),
    .in_a_y       (in_a_y),
    .in_a_z       (in_a_z),
    .in_b_w       (in_b_w),
    .in_b_x       (in_b_x),
    .in_b_y       (in_b_y),
    .in_b_z       (in_b_z),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_r_w      (out_r_w),
    .out_r_x      (out_r_x),
    .out_r_y      (out_r_y),
    .out_r_z      (out_r_z),
    .out_overflow (out_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Round to nearest at Q.30, ties toward plus infinity.
  function automatic wide_t round_q30(input wide_t v);
    return (v + (wide_t'(1) <<< 29)) >>> 30;
  endfunction

  // Clamp to 32 bits; flag any clamping.
  function automatic comp_t sat_q30(input wide_t v, output logic hit);
    hit = 1'b0;
    if (v > wide_t'(SAT_MAX)) begin
      hit = 1'b1;
      return SAT_MAX;
    end
    if (v < wide_t'(SAT_MIN)) begin
      hit = 1'b1;
      return SAT_MIN;
    end
    return v[31:0];
  endfunction

  // Compute the Hamilton product or the vector rotation of one request, at a
  // width where every sum is exact.
  function automatic quat_res_t quat_predict(input quat_req_t rq);
    wide_t     aw, ax, ay, az, bw, bx, by, bz;
    wide_t     sw, sx, sy, sz, tx, ty, tz, sgn;
    logic      h0, h1, h2, h3;
    quat_res_t res;
    aw = rq.aw; ax = rq.ax; ay = rq.ay; az = rq.az;
    bw = rq.bw; bx = rq.bx; by = rq.by; bz = rq.bz;
    res = '0;
    case (rq.cmd)
      CMD_MUL, CMD_CONJ_A, CMD_CONJ_B: begin
        if (rq.cmd == CMD_CONJ_A) begin
          ax = -ax; ay = -ay; az = -az;
        end
        if (rq.cmd == CMD_CONJ_B) begin
          bx = -bx; by = -by; bz = -bz;
        end
        sw = aw * bw - ax * bx - ay * by - az * bz;
        sx = aw * bx + ax * bw - ay * bz + az * by;
        sy = aw * by + ax * bz + ay * bw - az * bx;
        sz = aw * bz - ax * by + ay * bx + az * bw;
        res.rw  = sat_q30(round_q30(sw), h0);
        res.rx  = sat_q30(round_q30(sx), h1);
        res.ry  = sat_q30(round_q30(sy), h2);
        res.rz  = sat_q30(round_q30(sz), h3);
        res.ovf = h0 | h1 | h2 | h3;
      end
      CMD_ROT, CMD_ROT_CONJ: begin
        // t = 2 (av x v), kept unsaturated
        tx  = round_q30((ay * bz - az * by) <<< 1);
        ty  = round_q30((az * bx - ax * bz) <<< 1);
        tz  = round_q30((ax * by - ay * bx) <<< 1);
        sgn = (rq.cmd == CMD_ROT_CONJ) ? -aw : aw;
        sx  = ay * tz - az * ty + sgn * tx + (bx <<< 30);
        sy  = az * tx - ax * tz + sgn * ty + (by <<< 30);
        sz  = ax * ty - ay * tx + sgn * tz + (bz <<< 30);
        res.rx  = sat_q30(round_q30(sx), h1);
        res.ry  = sat_q30(round_q30(sy), h2);
        res.rz  = sat_q30(round_q30(sz), h3);
        res.ovf = h1 | h2 | h3;
      end
      default: begin
        res = '0;
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle patterns shared by both sides
  // ---------------------------------------------------------------------------

  // Pick an idle run: mostly short, now and then long.
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive out_stall: random stall runs, none started while no_gaps is set.
  always @(posedge clk) begin
    if (stall_left == 0 && !no_gaps && $urandom_range(0, 99) < 20)
      stall_left = idle_len();
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sending
  // ---------------------------------------------------------------------------

  // Present one request and hold it until the unit takes it. Lower valid only
  // across a gap, so back-to-back requests keep valid high without a glitch.
  task automatic send_request(input quat_req_t rq);
    int gap;
    gap = (!no_gaps && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= rq.cmd;
    in_a_w     <= rq.aw;
    in_a_x     <= rq.ax;
    in_a_y     <= rq.ay;
    in_a_z     <= rq.az;
    in_b_w     <= rq.bw;
    in_b_x     <= rq.bx;
    in_b_y     <= rq.by;
    in_b_z     <= rq.bz;
    // Advance until an edge sees valid high and stall low.
    do @(posedge clk); while (in_stall);
    pending_results.push_back(quat_predict(rq));
  endtask

  task automatic send_fields(input logic [2:0] cmd, input comp_t aw, input comp_t ax,
                             input comp_t ay, input comp_t az, input comp_t bw,
                             input comp_t bx, input comp_t by, input comp_t bz);
    quat_req_t rq;
    rq = '{cmd, aw, ax, ay, az, bw, bx, by, bz};
    send_request(rq);
  endtask

  // Mostly values within +-1.0 (the normal working range of a rotation),
  // plus full-range noise and the corner values.
  function automatic comp_t rand_comp();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return comp_t'($signed($urandom_range(0, 32'h8000_0000)) - ONE_Q30);
    if (sel < 90) return comp_t'($urandom());
    case ($urandom_range(0, 5))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return ONE_Q30;
      3: return MINUS_ONE_Q30;
      4: return comp_t'(1);
      default: return '0;
    endcase
  endfunction

  function automatic quat_req_t rand_request();
    quat_req_t rq;
    rq.cmd = ($urandom_range(0, 99) < 90) ? 3'($urandom_range(CMD_MUL, CMD_ROT_CONJ))
                                          : 3'($urandom());
    rq.aw = rand_comp(); rq.ax = rand_comp(); rq.ay = rand_comp(); rq.az = rand_comp();
    rq.bw = rand_comp(); rq.bx = rand_comp(); rq.by = rand_comp(); rq.bz = rand_comp();
    return rq;
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input comp_t want, input comp_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    quat_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h %h %h %h ovf=%b",
                 $time, out_r_w, out_r_x, out_r_y, out_r_z, out_overflow);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("r_w", want.rw, out_r_w);
        check_field("r_x", want.rx, out_r_x);
        check_field("r_y", want.ry, out_r_y);
        check_field("r_z", want.rz, out_r_z);
        if (want.ovf !== out_overflow) begin
          $display("%0t: overflow mismatch: expected %b, actual %b",
                   $time, want.ovf, out_overflow);
          mismatches++;
        end
      end
    end
  end

  // End the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Drive every command with all-maximum and all-minimum operands, and run the identity through each one.
  task automatic test_extremes();
    logic [2:0] c;
    for (int i = CMD_MUL; i <= CMD_ROT_CONJ; i++) begin
      c = 3'(i);
      send_fields(c, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
      send_fields(c, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
      send_fields(c, ONE_Q30, '0, '0, '0, rand_comp(), rand_comp(), rand_comp(), rand_comp());
    end
  endtask

  // Drive the spare command codes with live data; expect all zeros back.
  task automatic test_spare_commands();
    quat_req_t rq;
    for (int i = CMD_SPARE_FIRST; i <= CMD_SPARE_LAST; i++) begin
      rq     = rand_request();
      rq.cmd = 3'(i);
      send_request(rq);
    end
  endtask

  // Hit the exact half-LSB tie on both signs: +tie rounds up, -tie to zero.
  task automatic test_rounding_ties();
    send_fields(CMD_MUL, comp_t'(1), '0, '0, '0, HALF_LSB_Q30, '0, '0, '0);
    send_fields(CMD_MUL, comp_t'(-1), '0, '0, '0, HALF_LSB_Q30, '0, '0, '0);
    send_fields(CMD_MUL, comp_t'(3), '0, '0, '0, HALF_LSB_Q30, '0, '0, '0);
  endtask

  // Back-to-back requests; no new output stall run starts while they are sent.
  task automatic test_random_burst(input int count);
    no_gaps = 1'b1;
    repeat (count) send_request(rand_request());
    no_gaps = 1'b0;
  endtask

  // Random gaps and stalls on both sides.
  task automatic test_random_gappy(input int count);
    repeat (count) send_request(rand_request());
  endtask

  // Hold the sender until the pipe has drained, then resume.
  task automatic test_drain_pause(input int count);
    repeat (count) send_request(rand_request());
    // Drop valid so the last request is not taken again while draining.
    in_valid <= 1'b0;
    wait_drained();
    repeat (count) send_request(rand_request());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_spare_commands();
    test_rounding_ties();
    test_random_burst(300);
    test_random_gappy(1000);
    test_drain_pause(150);

    // Drop valid, drain, then let the pipe settle.
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
